### hw/rtl/rc_frame_decode_key_classifier_defines.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef RC_FRAME_DECODE_KEY_CLASSIFIER_DEFINES_SVH
`define RC_FRAME_DECODE_KEY_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define RCFD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcfd assertion failed");

// Next-cycle implication.
`define RCFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcfd assertion failed");

`else

`define RCFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define RCFD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/rcfd_pkg.sv
// Types, constants and helpers of the receiver frame decoder.
package rcfd_pkg;

   localparam int FRAME_LEN     = 18;
   localparam int POS_W         = 5;
   localparam int KEY_COUNT     = 18;
   localparam int COUNTER_WIDTH = 16;
   localparam int OUT_KEYS      = 18;
   localparam int KEY_PAD_W     = (KEY_COUNT > OUT_KEYS) ? KEY_COUNT : OUT_KEYS;
   localparam int CH_W          = 11;
   localparam int DB_W          = 10;
   localparam int TICK_W        = 16;
   localparam int CMP_W         = (COUNTER_WIDTH > TICK_W) ? COUNTER_WIDTH : TICK_W;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;
   localparam int RSP_BITS      = 161;
   localparam int RSP_DATA_W    = 168;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEADBAND    = 2'd0,
      REG_PRESS_TICKS = 2'd1,
      REG_LONG_TICKS  = 2'd2
   } csr_index_type;

   // First field sits in the highest bits.
   typedef struct packed {
      logic [OUT_KEYS-1:0] clicked_keys;
      logic [OUT_KEYS-1:0] long_pressed_keys;
      logic [OUT_KEYS-1:0] pressed_keys;
      logic signed [15:0]  mouse_dz;
      logic signed [15:0]  mouse_dy;
      logic signed [15:0]  mouse_dx;
      logic [3:0]          switches;
      logic signed [CH_W-1:0] wheel;
      logic signed [CH_W-1:0] left_y;
      logic signed [CH_W-1:0] left_x;
      logic signed [CH_W-1:0] right_y;
      logic signed [CH_W-1:0] right_x;
   } rsp_payload_type;

   // Center a raw 11-bit channel on zero and apply the deadband.
   function automatic logic signed [CH_W-1:0] centre_gate(
      input logic [CH_W-1:0] raw,
      input logic [DB_W-1:0] band
   );
      logic signed [CH_W:0] v;
      logic [CH_W:0]        mag;
      v   = $signed({1'b0, raw}) - $signed((CH_W+1)'(1024));
      mag = v[CH_W] ? (CH_W+1)'(-v) : (CH_W+1)'(v);
      if (mag < (CH_W+1)'(band)) begin
         return '0;
      end
      return v[CH_W-1:0];
   endfunction

endpackage

### hw/rtl/rc_frame_decode_key_classifier.sv
// Receiver frame decoder: stick/mouse unpacking and key hold classification.
//
//   channel | dir | words                       | handshake
//   req     | in  | one frame byte, start flag  | req_tvalid/req_tready
//   rsp     | out | one decoded frame           | rsp_tvalid/rsp_tready
//   csr     | in  | register writes             | csr_we, no wait
//
// One word accepted per cycle while req_tready is high. The 18th byte of
// a frame sets a decode flag; once the result register has room, the
// stored frame is decoded and the hold counters and result register are
// updated. Sync reset clears position, counters and flags and loads
// register defaults. req_tready drops only while a pending decode waits on
// a full, stalled result register.
`include "rc_frame_decode_key_classifier_defines.svh"

module rc_frame_decode_key_classifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] frame_byte
   input  logic                              req_tuser,   // [0] frame_start
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // right_x, right_y, left_x, left_y, wheel, switches, mouse_dx,
   // mouse_dy, mouse_dz, pressed_keys, long_pressed_keys, clicked_keys, pad
   output logic [rcfd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [rcfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rcfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // config
   logic [rcfd_pkg::DB_W-1:0]   deadband_ff;
   logic [rcfd_pkg::TICK_W-1:0] press_ticks_ff;
   logic [rcfd_pkg::TICK_W-1:0] long_ticks_ff;

   // frame capture
   logic [rcfd_pkg::POS_W-1:0] pos_ff, pos_in, pos_sel;
   logic [7:0] frame_ff [rcfd_pkg::FRAME_LEN];
   logic       decode_ff, decode_in;

   // key state
   logic [rcfd_pkg::COUNTER_WIDTH-1:0] cnt_ff [rcfd_pkg::KEY_COUNT];
   logic [rcfd_pkg::COUNTER_WIDTH-1:0] cnt_in [rcfd_pkg::KEY_COUNT];
   logic [rcfd_pkg::KEY_COUNT-1:0] press_ff, press_in;
   logic [rcfd_pkg::KEY_COUNT-1:0] long_ff, long_in;
   logic [rcfd_pkg::KEY_COUNT-1:0] click_ff, click_in;

   // result
   logic                      rsp_valid_ff, rsp_valid_in;
   rcfd_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic req_fire, out_free, decode_fire;
   logic [rcfd_pkg::KEY_PAD_W-1:0] keys_pad;
   logic [rcfd_pkg::KEY_PAD_W-1:0] press_pad, long_pad, click_pad;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !decode_ff || out_free;
   assign req_fire    = req_tvalid && req_tready;
   assign decode_fire = decode_ff && out_free;

   assign pos_sel   = req_tuser ? '0 : pos_ff;
   assign pos_in    = (pos_sel == rcfd_pkg::LAST_POS) ? '0 : pos_sel + 1'b1;
   // hold the decode request until the result register frees up
   assign decode_in = (req_fire && pos_sel == rcfd_pkg::LAST_POS) ||
                      (decode_ff && !out_free);

   // key word: keyboard bits, then the two mouse buttons (nonzero = held)
   always_comb begin
      keys_pad       = '0;
      keys_pad[15:0] = {frame_ff[15], frame_ff[14]};
      keys_pad[16]   = |frame_ff[12];
      keys_pad[17]   = |frame_ff[13];
   end

   // per-key hold counters and flags, all keys in parallel
   always_comb begin
      press_in = press_ff;
      long_in  = long_ff;
      click_in = click_ff;
      for (int i = 0; i < rcfd_pkg::KEY_COUNT; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (keys_pad[i]) begin
            if (cnt_ff[i] != '1) begin
               cnt_in[i] = cnt_ff[i] + 1'b1;
            end
            if (rcfd_pkg::CMP_W'(cnt_in[i]) > rcfd_pkg::CMP_W'(press_ticks_ff)) begin
               press_in[i] = 1'b1;
            end
            if (rcfd_pkg::CMP_W'(cnt_in[i]) > rcfd_pkg::CMP_W'(long_ticks_ff)) begin
               long_in[i] = 1'b1;
            end
            click_in[i] = 1'b0;
         end else begin
            // released between thresholds: one-frame click
            click_in[i] =
               (rcfd_pkg::CMP_W'(cnt_ff[i]) > rcfd_pkg::CMP_W'(press_ticks_ff)) &&
               (rcfd_pkg::CMP_W'(cnt_ff[i]) < rcfd_pkg::CMP_W'(long_ticks_ff));
            press_in[i] = 1'b0;
            long_in[i]  = 1'b0;
            cnt_in[i]   = '0;
         end
      end
      press_pad = rcfd_pkg::KEY_PAD_W'(press_in);
      long_pad  = rcfd_pkg::KEY_PAD_W'(long_in);
      click_pad = rcfd_pkg::KEY_PAD_W'(click_in);
   end

   // unpack the stored frame
   always_comb begin
      rsp_in.right_x = rcfd_pkg::centre_gate({frame_ff[1][2:0], frame_ff[0]}, deadband_ff);
      rsp_in.right_y = rcfd_pkg::centre_gate({frame_ff[2][5:0], frame_ff[1][7:3]},
                                             deadband_ff);
      rsp_in.left_x  = rcfd_pkg::centre_gate({frame_ff[4][0], frame_ff[3], frame_ff[2][7:6]},
                                             deadband_ff);
      rsp_in.left_y  = rcfd_pkg::centre_gate({frame_ff[5][3:0], frame_ff[4][7:1]},
                                             deadband_ff);
      rsp_in.wheel   = rcfd_pkg::centre_gate({frame_ff[17][2:0], frame_ff[16]}, deadband_ff);
      rsp_in.switches          = frame_ff[5][7:4];
      rsp_in.mouse_dx          = {frame_ff[7], frame_ff[6]};
      rsp_in.mouse_dy          = {frame_ff[9], frame_ff[8]};
      rsp_in.mouse_dz          = {frame_ff[11], frame_ff[10]};
      rsp_in.pressed_keys      = press_pad[rcfd_pkg::OUT_KEYS-1:0];
      rsp_in.long_pressed_keys = long_pad[rcfd_pkg::OUT_KEYS-1:0];
      rsp_in.clicked_keys      = click_pad[rcfd_pkg::OUT_KEYS-1:0];
   end

   assign rsp_valid_in = decode_fire || (rsp_valid_ff && !rsp_tready);

   // control and config
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         decode_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         press_ff       <= '0;
         long_ff        <= '0;
         click_ff       <= '0;
         deadband_ff    <= rcfd_pkg::DB_W'(20);
         press_ticks_ff <= rcfd_pkg::TICK_W'(10);
         long_ticks_ff  <= rcfd_pkg::TICK_W'(100);
         for (int i = 0; i < rcfd_pkg::KEY_COUNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         decode_ff    <= decode_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            pos_ff <= pos_in;
         end
         if (decode_fire) begin
            press_ff <= press_in;
            long_ff  <= long_in;
            click_ff <= click_in;
            for (int i = 0; i < rcfd_pkg::KEY_COUNT; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
         end
         if (csr_we) begin
            case (csr_index)
               rcfd_pkg::REG_DEADBAND:    deadband_ff    <= csr_wdata[rcfd_pkg::DB_W-1:0];
               rcfd_pkg::REG_PRESS_TICKS: press_ticks_ff <= csr_wdata[rcfd_pkg::TICK_W-1:0];
               rcfd_pkg::REG_LONG_TICKS:  long_ticks_ff  <= csr_wdata[rcfd_pkg::TICK_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_ff[pos_sel] <= req_tdata;
      end
      if (decode_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(rcfd_pkg::RSP_DATA_W - rcfd_pkg::RSP_BITS)'(0), rsp_ff};

   // a click never shows together with a press on the same key
   `RCFD_ASSERT_IMP(a_click_press_apart, clock, reset, rsp_tvalid,
      (rsp_ff.clicked_keys & rsp_ff.pressed_keys) == '0)
   // input stalls only behind a stalled, full result register
   `RCFD_ASSERT_IMP(a_stall_cause, clock, reset, !req_tready,
      decode_ff && rsp_valid_ff && !rsp_tready)
   // a decode with room in the result register produces a word
   `RCFD_ASSERT_NEXT(a_decode_emits, clock, reset, decode_ff && out_free, rsp_valid_ff)
   // the write position stays inside the frame
   `RCFD_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= rcfd_pkg::LAST_POS)

endmodule
